// ===== hw/rtl/multichannel_pid_feedforward_assert.svh =====
// Assertion macros shared by the RTL files. The clock is clk and the
// checks are off while rst is high.
`ifndef MULTICHANNEL_PID_FEEDFORWARD_ASSERT_SVH
`define MULTICHANNEL_PID_FEEDFORWARD_ASSERT_SVH

// Same-cycle implication.
`define MPF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mpf_pkg.sv =====
package mpf_pkg;

  // Number of actuator channels in the bank
  localparam int unsigned CHANNELS = 6;

  // Item operation codes
  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  // Configuration register indexes
  localparam logic [2:0] REG_PROP  = 3'd0;
  localparam logic [2:0] REG_INTEG = 3'd1;
  localparam logic [2:0] REG_DERIV = 3'd2;
  localparam logic [2:0] REG_FFWD  = 3'd3;

  // Q1.15 saturation limit
  localparam logic signed [15:0] LIM_Q15 = 16'sd32767;

  // Shared gains, unsigned Q16.16
  typedef struct packed {
    logic [31:0] prop;
    logic [31:0] integ;
    logic [31:0] deriv;
    logic [31:0] ffwd;
  } gains_t;

endpackage

// ===== hw/rtl/multichannel_pid_feedforward.sv =====
// Multichannel PID step with derivative on measurement and velocity
// feedforward. Each item is either a control step for one channel, which
// yields one drive result, or a clear of all integrals, which yields none;
// a step on a channel outside the bank is dropped without a result. The
// block takes one item per clock unless a step waits on a stalled result
// register: an item sits in the input register, the control law and the
// per-channel integral and previous position update happen while it sits
// there, and the drive is registered in the result register. Back-to-back
// steps on the same channel see each other's state with no stall. Gains are
// written through the configuration port (always ready); the user must write
// them only while no item is in flight, which the block itself does not enforce.
`include "multichannel_pid_feedforward_assert.svh"

module multichannel_pid_feedforward (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [2:0]         channel,
  input  logic signed [15:0] position_ref,
  input  logic signed [15:0] velocity_ref,
  input  logic signed [15:0] measured_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_channel,
  output logic signed [15:0] drive
);
  import mpf_pkg::*;

  gains_t             gains;
  logic signed [15:0] integral_sum [CHANNELS];
  logic signed [15:0] previous_position [CHANNELS];

  // Input register
  logic               s1_valid;
  op_t                s1_op;
  logic [2:0]         s1_channel;
  logic signed [15:0] s1_pos;
  logic signed [15:0] s1_vel;
  logic signed [15:0] s1_meas;

  logic               s1_hit;
  logic               s1_done;
  logic signed [15:0] integ_new;
  logic signed [15:0] drive_next;

  // A step on a channel in the bank gives a result
  assign s1_hit  = (s1_op == OP_STEP) && (32'(s1_channel) < CHANNELS);
  assign s1_done = s1_valid && (!s1_hit || !out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_done;
  assign cfg_ready = 1'b1;

  // Gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gains <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROP:  gains.prop  <= cfg_data;
        REG_INTEG: gains.integ <= cfg_data;
        REG_DERIV: gains.deriv <= cfg_data;
        REG_FFWD:  gains.ffwd  <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Input register load
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_op      <= op_t'(operation);
      s1_channel <= channel;
      s1_pos     <= position_ref;
      s1_vel     <= velocity_ref;
      s1_meas    <= measured_position;
    end
  end

  mpf_law u_law (
    .gains             (gains),
    .position_ref      (s1_pos),
    .velocity_ref      (s1_vel),
    .measured_position (s1_meas),
    .prev_position     (previous_position[s1_channel]),
    .integ_old         (integral_sum[s1_channel]),
    .integ_new         (integ_new),
    .drive             (drive_next)
  );

  // Per-channel state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        integral_sum[i]      <= '0;
        previous_position[i] <= '0;
      end
    end else if (s1_done) begin
      if (s1_op == OP_CLEAR) begin
        for (int i = 0; i < CHANNELS; i++) begin
          integral_sum[i] <= '0;
        end
      end else if (s1_hit) begin
        integral_sum[s1_channel]      <= integ_new;
        previous_position[s1_channel] <= s1_meas;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_done && s1_hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_done && s1_hit) begin
      out_channel <= s1_channel;
      drive       <= drive_next;
    end
  end

  // Checks
  `MPF_ASSERT_IMPL(a_drive_sat, out_valid, drive != 16'sh8000, "drive outside saturation range")
  `MPF_ASSERT_IMPL(a_integ_range, s1_valid && s1_hit, integral_sum[s1_channel] != 16'sh8000, "integral outside clamp range")
  `MPF_ASSERT_NEXT(a_clear_zero, s1_done && (s1_op == OP_CLEAR), integral_sum[0] == 16'sd0, "clear left an integral set")
  `MPF_ASSERT_NEXT(a_step_result, s1_done && s1_hit, out_valid && (out_channel == $past(s1_channel)), "step result missing")
  `MPF_ASSERT_IMPL(a_stall_hold, s1_valid && s1_hit && out_valid && !out_ready, !in_ready, "item taken while result stalled")

endmodule

// ===== hw/rtl/mpf_law.sv =====
// Control law for one step: integral update and drive, all combinational.
module mpf_law (
  input  mpf_pkg::gains_t     gains,
  input  logic signed [15:0]  position_ref,
  input  logic signed [15:0]  velocity_ref,
  input  logic signed [15:0]  measured_position,
  input  logic signed [15:0]  prev_position,
  input  logic signed [15:0]  integ_old,
  output logic signed [15:0]  integ_new,
  output logic signed [15:0]  drive
);
  import mpf_pkg::*;

  // Integral clamp in Q.31: 32767 << 16
  localparam logic signed [50:0] T_HI = 51'sd2147418112;
  localparam logic signed [50:0] T_LO = -51'sd2147418112;
  localparam logic signed [36:0] Q_HI = 37'(LIM_Q15);
  localparam logic signed [36:0] Q_LO = -37'(LIM_Q15);

  logic signed [16:0] err;
  logic signed [16:0] delta;
  logic signed [16:0] vel;
  logic signed [49:0] p_prop;
  logic signed [49:0] p_integ;
  logic signed [49:0] p_deriv;
  logic signed [49:0] p_ffwd;
  logic signed [50:0] t_sum;
  logic signed [50:0] t_clamp;
  logic signed [50:0] t_round;
  logic signed [52:0] d_sum;
  logic signed [52:0] d_round;
  logic signed [36:0] d_q15;

  // Exact 17-bit differences
  assign err   = {position_ref[15], position_ref} - {measured_position[15], measured_position};
  assign delta = {measured_position[15], measured_position} - {prev_position[15], prev_position};
  assign vel   = {velocity_ref[15], velocity_ref};

  // Gain products, Q16.16 times Q.15 gives Q.31
  assign p_prop  = $signed({1'b0, gains.prop})  * err;
  assign p_integ = $signed({1'b0, gains.integ}) * err;
  assign p_deriv = $signed({1'b0, gains.deriv}) * delta;
  assign p_ffwd  = $signed({1'b0, gains.ffwd})  * vel;

  // Integral: accumulate, clamp to +-1, round half up to Q.15
  always_comb begin
    t_sum = $signed({{19{integ_old[15]}}, integ_old, 16'h0000})
          + $signed({p_integ[49], p_integ});
    if (t_sum > T_HI) begin
      t_clamp = T_HI;
    end else if (t_sum < T_LO) begin
      t_clamp = T_LO;
    end else begin
      t_clamp = t_sum;
    end
    t_round   = t_clamp + 51'sd32768;
    integ_new = t_round[31:16];
  end

  // Drive: four-term sum, round half up, saturate to +-1
  always_comb begin
    d_sum = $signed({{3{p_prop[49]}}, p_prop})
          + $signed({{21{integ_new[15]}}, integ_new, 16'h0000})
          - $signed({{3{p_deriv[49]}}, p_deriv})
          + $signed({{3{p_ffwd[49]}}, p_ffwd});
    d_round = d_sum + 53'sd32768;
    d_q15   = d_round[52:16];
    if (d_q15 > Q_HI) begin
      drive = LIM_Q15;
    end else if (d_q15 < Q_LO) begin
      drive = -LIM_Q15;
    end else begin
      drive = d_q15[15:0];
    end
  end

endmodule

// ===== test/pid_drive_checker.sv =====
module pid_drive_checker
  import mpf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               operation,
  input  logic [2:0]         channel,
  input  logic signed [15:0] position_ref,
  input  logic signed [15:0] velocity_ref,
  input  logic signed [15:0] measured_position,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         out_channel,
  input  logic signed [15:0] drive,
  output int                 fail_count,
  output int                 outstanding
);

  typedef struct packed {
    logic [2:0]         chan;
    logic signed [15:0] drive;
  } drive_result_t;

  // Integral clamp in Q.31
  localparam longint INTEG_LIM_Q31 = longint'(LIM_Q15) * 65536;

  // Shadow of the block's gains and per-channel state
  gains_t             gains;
  logic signed [15:0] integ_q15 [CHANNELS];
  logic signed [15:0] prev_pos  [CHANNELS];
  drive_result_t      drives_due [$];
  int                 cycle_no;

  function automatic longint clip(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Q.31 to Q.15, ties toward plus infinity
  function automatic longint round_q15(input longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  // One control law step; returns 1 when the item yields a drive
  function automatic bit pid_step(input op_t op, input logic [2:0] ch,
                                  input logic signed [15:0] pos_ref,
                                  input logic signed [15:0] vel_ref,
                                  input logic signed [15:0] meas,
                                  output drive_result_t res);
    longint err;
    longint delta;
    longint acc;
    res = '0;
    if (op == OP_CLEAR) begin
      foreach (integ_q15[i]) integ_q15[i] = '0;
      return 1'b0;
    end
    if (ch >= CHANNELS) return 1'b0;

    err   = longint'(pos_ref) - longint'(meas);
    delta = longint'(meas) - longint'(prev_pos[ch]);

    // integral update, clamped before rounding
    acc = longint'(integ_q15[ch]) * 65536 + longint'(gains.integ) * err;
    integ_q15[ch] = 16'(round_q15(clip(acc, INTEG_LIM_Q31)));

    acc = longint'(gains.prop) * err
        + longint'(integ_q15[ch]) * 65536
        - longint'(gains.deriv) * delta
        + longint'(gains.ffwd) * longint'(vel_ref);
    res.chan  = ch;
    res.drive = 16'(clip(round_q15(acc), longint'(LIM_Q15)));
    prev_pos[ch] = meas;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < 40)
      $display("drive check: %s got %0d expected %0d (cycle %0d)", what, got, want,
               cycle_no);
    fail_count++;
  endtask

  // Sample all channels at the clock edge
  always @(posedge clk) begin : watch
    drive_result_t want;
    drive_result_t got;
    cycle_no++;
    if (rst) begin
      gains = '0;
      foreach (integ_q15[i]) begin
        integ_q15[i] = '0;
        prev_pos[i]  = '0;
      end
      drives_due.delete();
    end else begin
      // gain writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROP:  gains.prop  = cfg_data;
          REG_INTEG: gains.integ = cfg_data;
          REG_DERIV: gains.deriv = cfg_data;
          REG_FFWD:  gains.ffwd  = cfg_data;
          default: ;
        endcase
      end

      // compare drive results against the oldest prediction
      if (out_valid && out_ready) begin
        got.chan  = out_channel;
        got.drive = drive;
        if (drives_due.size() == 0) begin
          report_mismatch("unexpected drive, channel", int'(got.chan), -1);
        end else begin
          want = drives_due.pop_front();
          if (got.chan !== want.chan)
            report_mismatch("out_channel", int'(got.chan), int'(want.chan));
          if (got.drive !== want.drive)
            report_mismatch("drive", int'(got.drive), int'(want.drive));
        end
      end

      // predict from accepted items
      if (in_valid && in_ready) begin
        if (pid_step(op_t'(operation), channel, position_ref, velocity_ref,
                     measured_position, want))
          drives_due.push_back(want);
      end
    end
    outstanding <= drives_due.size();
  end

endmodule

// ===== test/multichannel_pid_feedforward_tb.sv =====
module multichannel_pid_feedforward_tb;
  import mpf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 200;

  typedef enum int {MIX_MODERATE, MIX_FULL, MIX_SMALL} gain_mix_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               operation;
  logic [2:0]         channel;
  logic signed [15:0] position_ref;
  logic signed [15:0] velocity_ref;
  logic signed [15:0] measured_position;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_channel;
  logic signed [15:0] drive;
  int                 fail_count;
  int                 outstanding;

  // stimulus-side state
  int target_pos [CHANNELS];
  int plant_pos  [CHANNELS];
  bit steady_send;
  int hold_req;
  int cycle_count;

  always #2 clk = ~clk;

  multichannel_pid_feedforward i_dut (.*);

  pid_drive_checker i_checker (.*);

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic gains_t pick_gains(input gain_mix_t mix);
    gains_t g;
    case (mix)
      MIX_MODERATE: begin
        g.prop  = $urandom_range(0, 32'h40000);
        g.integ = $urandom_range(0, 32'h4000);
        g.deriv = $urandom_range(0, 32'h40000);
        g.ffwd  = $urandom_range(0, 32'h20000);
      end
      MIX_SMALL: begin
        g.prop  = $urandom_range(0, 32'h800);
        g.integ = $urandom_range(0, 32'h100);
        g.deriv = $urandom_range(0, 32'h800);
        g.ffwd  = $urandom_range(0, 32'h800);
      end
      default: begin
        g.prop  = $urandom;
        g.integ = $urandom;
        g.deriv = $urandom;
        g.ffwd  = $urandom;
      end
    endcase
    return g;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // all four gains plus one write to an index past the register list
  task automatic write_gains(input gains_t g);
    write_reg(REG_PROP, g.prop);
    write_reg(REG_INTEG, g.integ);
    write_reg(REG_DERIV, g.deriv);
    write_reg(REG_FFWD, g.ffwd);
    write_reg(REG_FFWD + 3'($urandom_range(1, 4)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input op_t op, input logic [2:0] ch,
                           input logic signed [15:0] pref,
                           input logic signed [15:0] vref,
                           input logic signed [15:0] meas);
    int gap;
    gap = steady_send ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    operation         <= op;
    channel           <= ch;
    position_ref      <= pref;
    velocity_ref      <= vref;
    measured_position <= meas;
    do @(posedge clk); while (!in_ready);
  endtask

  // let the pipe empty before touching the gains
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // mostly a tracking loop per channel, the rest noise and odd items
  task automatic send_random_item();
    int r;
    int ch;
    int vel;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      send_item(OP_CLEAR, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else if (r < 8) begin
      send_item(OP_STEP, 3'($urandom_range(CHANNELS, 7)), 16'($urandom),
                16'($urandom), 16'($urandom));
    end else if (r < 22) begin
      send_item(op_t'($urandom_range(0, 1)), 3'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom));
    end else begin
      ch = $urandom_range(0, CHANNELS - 1);
      if ($urandom_range(0, 9) == 0)
        target_pos[ch] = int'($urandom_range(0, 65535)) - 32768;
      plant_pos[ch] = clamp16(plant_pos[ch] + (target_pos[ch] - plant_pos[ch]) / 4
                              + int'($urandom_range(0, 128)) - 64);
      if ($urandom_range(0, 9) < 3)
        vel = int'($urandom_range(0, 65535)) - 32768;
      else
        vel = (target_pos[ch] - plant_pos[ch]) / 8;
      send_item(OP_STEP, 3'(ch), 16'(target_pos[ch]), 16'(vel), 16'(plant_pos[ch]));
    end
  endtask

  // result side: random stalls, free-running stretches, one long hold-off
  initial begin : result_side
    int stall_left;
    int steady_left;
    int hold_left;
    int hold_seen;
    stall_left  = 0;
    steady_left = 0;
    hold_left   = 0;
    hold_seen   = 0;
    out_ready   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (steady_left > 0) begin
        steady_left--;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 49) == 0)
          steady_left = 80;
        else
          stall_left = idle_gap();
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("multichannel_pid_feedforward regression: fail");
    $finish;
  end

  // stimulus
  initial begin
    rst               <= 1'b1;
    cfg_valid         <= 1'b0;
    cfg_index         <= REG_PROP;
    cfg_data          <= '0;
    in_valid          <= 1'b0;
    operation         <= OP_STEP;
    channel           <= '0;
    position_ref      <= '0;
    velocity_ref      <= '0;
    measured_position <= '0;
    hold_req          <= 0;
    steady_send       = 1'b0;
    foreach (target_pos[i]) begin
      target_pos[i] = 0;
      plant_pos[i]  = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // gains still at reset: drive must be zero
    send_item(OP_STEP, 3'd0, 16'sd1000, -16'sd2000, -16'sd500);
    send_item(OP_STEP, 3'd5, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_item(OP_STEP, 3'd3, -16'sd7, 16'sd9, 16'sd12);
    settle();

    // unity gains: extremes, each channel, clear, channels outside the bank
    write_gains('{prop: 32'h10000, integ: 32'h10000, deriv: 32'h10000, ffwd: 32'h10000});
    send_item(OP_STEP, 3'd0, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_item(OP_STEP, 3'd1, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_item(OP_STEP, 3'd2, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_STEP, 3'd3, 16'sd16384, 16'sd1, 16'sd16384);
    send_item(OP_STEP, 3'd4, -16'sd1, -16'sd1, 16'sd0);
    send_item(OP_STEP, 3'd5, 16'sd100, 16'sd0, -16'sd100);
    send_item(OP_CLEAR, 3'd0, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_STEP, 3'd0, 16'sd200, 16'sd0, 16'sd100);
    send_item(OP_STEP, 3'd6, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_item(OP_STEP, 3'd7, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_item(OP_STEP, 3'd5, 16'sd100, 16'sd0, -16'sd100);
    settle();

    // full-scale gains: integral clamp and drive saturation
    write_gains('{prop: '1, integ: '1, deriv: '1, ffwd: '1});
    send_item(OP_STEP, 3'd0, 16'sd1, 16'sd0, 16'sd0);
    send_item(OP_STEP, 3'd0, -16'sd1, 16'sd0, 16'sd0);
    send_item(OP_STEP, 3'd1, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_item(OP_STEP, 3'd1, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_item(OP_STEP, 3'd2, 16'sd0, -16'sd1, 16'sd0);
    settle();

    // half-LSB products: rounding ties go up
    write_gains('{prop: 32'h8000, integ: 32'h8000, deriv: 32'h18000, ffwd: 32'h8000});
    send_item(OP_STEP, 3'd0, 16'sd1, 16'sd0, 16'sd0);
    send_item(OP_STEP, 3'd1, -16'sd1, 16'sd0, 16'sd0);
    send_item(OP_STEP, 3'd2, 16'sd0, 16'sd1, 16'sd0);
    send_item(OP_STEP, 3'd3, 16'sd0, -16'sd3, 16'sd0);
    send_item(OP_STEP, 3'd4, 16'sd0, 16'sd0, 16'sd3);

    // random phases, each under its own gain set
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_gains(pick_gains(gain_mix_t'(p % 3)));
      if (p == 1) begin
        // hold off the result side while items keep coming
        hold_req <= hold_req + 1;
        steady_send = 1'b1;
        repeat (60) send_random_item();
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        steady_send = (n >= 100 && n < 140);
        send_random_item();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("multichannel_pid_feedforward regression: pass");
    else
      $display("multichannel_pid_feedforward regression: fail");
    $finish;
  end

endmodule
